FILE: rtl/scanline_fir_replicate_border_assert.svh
// Assertion macros used by the scanline filter checker.
`ifndef SCANLINE_FIR_REPLICATE_BORDER_ASSERT_SVH
`define SCANLINE_FIR_REPLICATE_BORDER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SFIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SFIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sfir_pkg.sv
// Shared constants, types and register codes of the scanline filter.
package sfir_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int RADIUS_MAX = 6;
    localparam int LINE_MAX   = 4096;

    localparam int WIN_LEN    = 2 * RADIUS_MAX + 1;
    localparam int NUM_WGT    = RADIUS_MAX + 1;
    localparam int WGT_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int RAD_W      = 3;
    localparam int CNT_W      = $clog2(LINE_MAX);
    localparam int WIN_IDX_W  = $clog2(WIN_LEN);
    localparam int WGT_IDX_W  = $clog2(NUM_WGT);
    localparam int PAIR_W     = PIXEL_BITS + 1;
    localparam int PROD_W     = WGT_W + PAIR_W;
    localparam int ACC_W      = PROD_W + $clog2(NUM_WGT);
    localparam int HALF_WGT   = (NUM_WGT + 1) / 2;
    localparam int PSUM_W     = PROD_W + $clog2(HALF_WGT + 1);
    localparam int Q_W        = ACC_W - FRAC_W;
    localparam int TDATA_W    = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int CFG_ADDR_W = $clog2(NUM_WGT + 1);
    localparam int CFG_DATA_W = WGT_W;
    localparam int WGT_VEC_W  = NUM_WGT * WGT_W;

    localparam logic [CFG_ADDR_W-1:0] REG_TAP_RADIUS  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_0    = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_LAST = CFG_ADDR_W'(NUM_WGT);

    localparam logic [WGT_W-1:0] WGT_CENTRE_RST = '1;
    localparam logic [NUM_WGT-1:0][WGT_W-1:0] WGT_RST = WGT_VEC_W'(WGT_CENTRE_RST);
    localparam logic [RAD_W-1:0] RAD_MAX_V      = RAD_W'(RADIUS_MAX);
    localparam logic [ACC_W-1:0] RND_HALF       = ACC_W'(1) << (FRAC_W - 1);

    typedef logic [PIXEL_BITS-1:0]                t_pix;
    typedef logic [WIN_LEN-1:0][PIXEL_BITS-1:0]   t_win;
    typedef logic [RADIUS_MAX-1:0][PAIR_W-1:0]    t_pair_vec;
    typedef logic [NUM_WGT-1:0][PROD_W-1:0]       t_prod_vec;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic [RAD_W-1:0]                radius;
        logic [NUM_WGT-1:0][WGT_W-1:0]   weight;
    } t_cfg;

endpackage

FILE: rtl/scanline_fir_replicate_border.sv
// Top level of the symmetric scanline FIR filter with replicated borders.
//
// Slave stream: one pixel per transfer, tlast on the last pixel of a line.
// Master stream: one filtered pixel per transfer, tlast on the line's last result.
// Config port: write enable, register index, data; write only while idle, not enforced here.
// Register 0 is the tap radius r, registers 1 to 7 the weights for distance 0 to 6.
// The result for pixel p is formed once pixel p+r is transferred, then passes the window,
// tap, multiplier and adder stages into the output register: a five-stage pipeline.
// Throughput: one pixel per clock inside a line while the master side does not stall.
// A tlast transfer starts a flush, input held off: while the window stage is free,
// the newest pixel replays once per clock for the line's last results, r at most.
// Reset clears the pipeline valid bits, the line counter and the flush state;
// the window needs no clearing, the first pixel of each line fills it.
// When the master side stalls, the result holds in the output register and the
// earlier stages keep filling; the slave side stops only once all are occupied.
module scanline_fir_replicate_border (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfir_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sfir_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [sfir_pkg::TDATA_W-1:0]        i_s_axis_tdata,   // [15:0] pixel
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [sfir_pkg::TDATA_W-1:0]        o_m_axis_tdata,   // [15:0] filtered
    output logic                                o_m_axis_tlast
);

    sfir_pkg::t_cfg         cfg;
    sfir_pkg::t_ctl         s0_ctl;
    sfir_pkg::t_ctl         s2_ctl;
    sfir_pkg::t_win         win;
    sfir_pkg::t_prod_vec    prod;
    sfir_pkg::t_pix         filtered;
    logic                   s1_free;
    logic                   s2_free;

    sfir_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sfir_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_pixel    (i_s_axis_tdata[sfir_pkg::PIXEL_BITS-1:0]),
        .i_line_end (i_s_axis_tlast),
        .i_radius   (cfg.radius),
        .i_s1_free  (s1_free),
        .o_ctl      (s0_ctl),
        .o_win      (win)
    );

    sfir_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s0_ctl),
        .i_win     (win),
        .i_cfg     (cfg),
        .i_s2_free (s2_free),
        .o_s1_free (s1_free),
        .o_ctl     (s2_ctl),
        .o_prod    (prod)
    );

    sfir_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s2_ctl),
        .i_prod     (prod),
        .o_s2_free  (s2_free),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_filtered (filtered),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = sfir_pkg::TDATA_W'(filtered);

endmodule

FILE: rtl/sfir_regs.sv
// Configuration registers: tap radius and the seven tap weights.
module sfir_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfir_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sfir_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output sfir_pkg::t_cfg                      o_cfg
);

    logic [sfir_pkg::RAD_W-1:0]                          r_radius;
    logic [sfir_pkg::NUM_WGT-1:0][sfir_pkg::WGT_W-1:0]   r_weight;
    logic [sfir_pkg::WGT_IDX_W-1:0]                      wgt_idx;

    assign wgt_idx = sfir_pkg::WGT_IDX_W'(i_cfg_addr - sfir_pkg::REG_WEIGHT_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_weight <= sfir_pkg::WGT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr) inside
                sfir_pkg::REG_TAP_RADIUS: begin
                    r_radius <= i_cfg_wdata[sfir_pkg::RAD_W-1:0];
                end
                [sfir_pkg::REG_WEIGHT_0:sfir_pkg::REG_WEIGHT_LAST]: begin
                    r_weight[wgt_idx] <= i_cfg_wdata[sfir_pkg::WGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp radius above RADIUS_MAX to RADIUS_MAX
    assign o_cfg.radius = (r_radius > sfir_pkg::RAD_MAX_V) ? sfir_pkg::RAD_MAX_V : r_radius;
    assign o_cfg.weight = r_weight;

endmodule

FILE: rtl/sfir_window.sv
// Pixel window, line position counter and end-of-line flush sequencer.
module sfir_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  sfir_pkg::t_pix              i_pixel,
    input  logic                        i_line_end,
    input  logic [sfir_pkg::RAD_W-1:0]  i_radius,
    input  logic                        i_s1_free,
    output sfir_pkg::t_ctl              o_ctl,
    output sfir_pkg::t_win              o_win
);

    sfir_pkg::t_win                 r_win;
    sfir_pkg::t_win                 n_win;
    sfir_pkg::t_ctl                 r_s0;
    sfir_pkg::t_ctl                 n_s0;
    logic [sfir_pkg::CNT_W-1:0]     r_cnt;
    logic [sfir_pkg::CNT_W-1:0]     n_cnt;
    logic                           r_fl_act;
    logic                           n_fl_act;
    logic [sfir_pkg::RAD_W-1:0]     r_fl_s;
    logic [sfir_pkg::RAD_W-1:0]     n_fl_s;
    logic [sfir_pkg::RAD_W-1:0]     r_fl_gap;
    logic [sfir_pkg::RAD_W-1:0]     n_fl_gap;

    logic                           s0_free;
    logic                           accept;
    logic                           step;
    logic                           n_ge_r;
    logic [sfir_pkg::RAD_W-1:0]     gap;
    logic [sfir_pkg::RAD_W-1:0]     fl_s_inc;
    logic [sfir_pkg::CNT_W-1:0]     cnt_inc;

    assign s0_free    = !r_s0.valid || i_s1_free;
    assign o_s_tready = s0_free && !r_fl_act;
    assign accept     = i_s_tvalid && o_s_tready;
    assign step       = s0_free && r_fl_act;

    assign n_ge_r   = r_cnt >= sfir_pkg::CNT_W'(i_radius);
    assign gap      = n_ge_r ? '0 : i_radius - r_cnt[sfir_pkg::RAD_W-1:0];
    assign fl_s_inc = r_fl_s + 1'b1;
    assign cnt_inc  = (r_cnt == sfir_pkg::CNT_W'(sfir_pkg::LINE_MAX - 1)) ? r_cnt
                                                                          : r_cnt + 1'b1;

    // first pixel of a line fills the window: left border replication
    // flush steps push the newest pixel again: right border replication
    always_comb begin
        n_win = r_win;
        if (accept) begin
            if (r_cnt == '0) begin
                n_win = {sfir_pkg::WIN_LEN{i_pixel}};
            end else begin
                n_win = {r_win[sfir_pkg::WIN_LEN-2:0], i_pixel};
            end
        end else if (step) begin
            n_win = {r_win[sfir_pkg::WIN_LEN-2:0], r_win[0]};
        end
    end

    always_comb begin
        n_s0     = r_s0;
        n_cnt    = r_cnt;
        n_fl_act = r_fl_act;
        n_fl_s   = r_fl_s;
        n_fl_gap = r_fl_gap;
        if (accept) begin
            n_s0.valid = n_ge_r;
            if (i_line_end) begin
                n_s0.last = (i_radius == '0);
                n_cnt     = '0;
                n_fl_act  = (i_radius != '0);
                n_fl_s    = '0;
                n_fl_gap  = gap;
            end else begin
                n_s0.last = 1'b0;
                n_cnt     = cnt_inc;
            end
        end else if (step) begin
            n_s0.valid = (fl_s_inc >= r_fl_gap);
            n_s0.last  = (fl_s_inc == i_radius);
            n_fl_act   = (fl_s_inc != i_radius);
            n_fl_s     = fl_s_inc;
        end else if (s0_free) begin
            n_s0.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0     <= '0;
            r_cnt    <= '0;
            r_fl_act <= 1'b0;
            r_fl_s   <= '0;
            r_fl_gap <= '0;
        end else begin
            r_s0     <= n_s0;
            r_cnt    <= n_cnt;
            r_fl_act <= n_fl_act;
            r_fl_s   <= n_fl_s;
            r_fl_gap <= n_fl_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_ctl = r_s0;
    assign o_win = r_win;

endmodule

FILE: rtl/sfir_mac.sv
// Tap selection with symmetric pair sums, then one multiplier per weight.
module sfir_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfir_pkg::t_ctl      i_ctl,
    input  sfir_pkg::t_win      i_win,
    input  sfir_pkg::t_cfg      i_cfg,
    input  logic                i_s2_free,
    output logic                o_s1_free,
    output sfir_pkg::t_ctl      o_ctl,
    output sfir_pkg::t_prod_vec o_prod
);

    sfir_pkg::t_ctl                 r_s1;
    sfir_pkg::t_pix                 r_ctr;
    sfir_pkg::t_pair_vec            r_pair;
    sfir_pkg::t_ctl                 r_s2;
    sfir_pkg::t_prod_vec            r_prod;

    logic [sfir_pkg::WIN_IDX_W-1:0] ctr_idx;
    sfir_pkg::t_pix                 n_ctr;
    sfir_pkg::t_pair_vec            n_pair;
    sfir_pkg::t_prod_vec            n_prod;
    logic                           s2_free;

    assign s2_free   = !r_s2.valid || i_s2_free;
    assign o_s1_free = !r_s1.valid || s2_free;
    assign ctr_idx   = sfir_pkg::WIN_IDX_W'(i_cfg.radius);
    assign n_ctr     = i_win[ctr_idx];

    // zero pairs beyond the radius
    always_comb begin
        for (int d = 1; d <= sfir_pkg::RADIUS_MAX; d++) begin
            if (d <= int'(i_cfg.radius)) begin
                n_pair[d-1] =
                    sfir_pkg::PAIR_W'(i_win[ctr_idx - sfir_pkg::WIN_IDX_W'(d)]) +
                    sfir_pkg::PAIR_W'(i_win[ctr_idx + sfir_pkg::WIN_IDX_W'(d)]);
            end else begin
                n_pair[d-1] = '0;
            end
        end
    end

    always_comb begin
        n_prod[0] = sfir_pkg::PROD_W'(i_cfg.weight[0]) * sfir_pkg::PROD_W'(r_ctr);
        for (int d = 1; d < sfir_pkg::NUM_WGT; d++) begin
            n_prod[d] = sfir_pkg::PROD_W'(i_cfg.weight[d]) * sfir_pkg::PROD_W'(r_pair[d-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            if (o_s1_free) begin
                r_s1 <= i_ctl;
            end
            if (s2_free) begin
                r_s2 <= r_s1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_free) begin
            r_ctr  <= n_ctr;
            r_pair <= n_pair;
        end
        if (s2_free) begin
            r_prod <= n_prod;
        end
    end

    assign o_ctl  = r_s2;
    assign o_prod = r_prod;

endmodule

FILE: rtl/sfir_round.sv
// Product summation, round to nearest, saturation and output register.
module sfir_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfir_pkg::t_ctl      i_ctl,
    input  sfir_pkg::t_prod_vec i_prod,
    output logic                o_s2_free,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output sfir_pkg::t_pix      o_filtered,
    output logic                o_last
);

    sfir_pkg::t_ctl                 r_s3;
    logic [sfir_pkg::PSUM_W-1:0]    r_sa;
    logic [sfir_pkg::PSUM_W-1:0]    r_sb;
    sfir_pkg::t_ctl                 r_out;
    sfir_pkg::t_pix                 r_filt;

    logic [sfir_pkg::PSUM_W-1:0]    n_sa;
    logic [sfir_pkg::PSUM_W-1:0]    n_sb;
    logic [sfir_pkg::ACC_W-1:0]     tot;
    logic [sfir_pkg::Q_W-1:0]       q;
    sfir_pkg::t_pix                 n_filt;
    logic                           out_free;
    logic                           s3_free;

    assign out_free  = !r_out.valid || i_m_tready;
    assign s3_free   = !r_s3.valid || out_free;
    assign o_s2_free = s3_free;

    always_comb begin
        n_sa = '0;
        n_sb = '0;
        for (int i = 0; i < sfir_pkg::HALF_WGT; i++) begin
            n_sa = n_sa + sfir_pkg::PSUM_W'(i_prod[i]);
        end
        for (int i = sfir_pkg::HALF_WGT; i < sfir_pkg::NUM_WGT; i++) begin
            n_sb = n_sb + sfir_pkg::PSUM_W'(i_prod[i]);
        end
    end

    assign tot    = sfir_pkg::ACC_W'(r_sa) + sfir_pkg::ACC_W'(r_sb) + sfir_pkg::RND_HALF;
    assign q      = tot[sfir_pkg::ACC_W-1:sfir_pkg::FRAC_W];
    assign n_filt = (|q[sfir_pkg::Q_W-1:sfir_pkg::PIXEL_BITS]) ? '1
                                                              : q[sfir_pkg::PIXEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3  <= '0;
            r_out <= '0;
        end else begin
            if (s3_free) begin
                r_s3 <= i_ctl;
            end
            if (out_free) begin
                r_out <= r_s3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
        end
        if (out_free) begin
            r_filt <= n_filt;
        end
    end

    assign o_m_tvalid = r_out.valid;
    assign o_last     = r_out.last;
    assign o_filtered = r_filt;

endmodule

FILE: rtl/sfir_checker.sv
// Port-level checker of the scanline filter, bound to the top level.
`include "scanline_fir_replicate_border_assert.svh"

module sfir_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                o_s_axis_tready,
    input  logic                                i_s_axis_tlast,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [sfir_pkg::TDATA_W-1:0]        o_m_axis_tdata,
    input  logic                                o_m_axis_tlast
);

    logic                           end_xfer;
    logic [sfir_pkg::RAD_W-1:0]     r_drain_cnt;
    logic [sfir_pkg::RAD_W-1:0]     n_drain_cnt;

    assign end_xfer = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;

    // count clocks of free-running output since the last line end
    always_comb begin
        n_drain_cnt = r_drain_cnt;
        if (end_xfer || !i_m_axis_tready) begin
            n_drain_cnt = '0;
        end else if (r_drain_cnt != sfir_pkg::RAD_MAX_V) begin
            n_drain_cnt = r_drain_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_cnt <= '0;
        end else begin
            r_drain_cnt <= n_drain_cnt;
        end
    end

    `SFIR_ASSERT_IMP(a_reset_idle, i_rst_n && $past(!i_rst_n), o_s_axis_tready && !o_m_axis_tvalid, "pipeline not empty after reset")
    `SFIR_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")
    `SFIR_ASSERT_IMP(a_flush_bounded, i_m_axis_tready && (r_drain_cnt == sfir_pkg::RAD_MAX_V), o_s_axis_tready, "line end flush did not finish")

endmodule

bind scanline_fir_replicate_border sfir_checker u_sfir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
